>>> hdl/spbj_pkg.sv
// spbj_pkg: widths, constants and shared types of the spectral bin jitter block
// no dependencies; the rtl files refer to it by scoped names, the bench imports it
`timescale 1ns / 1ps

package spbj_pkg;

   localparam int DATA_W    = 32;
   localparam int STATE_W   = 31;
   localparam int BIN_W     = 11;
   localparam int DIVR_W    = BIN_W + 1;
   localparam int QUO_W     = 31;
   localparam int MULT_W    = 30;
   localparam int PROD_W    = STATE_W + MULT_W;
   localparam int NUM_W     = 2 * DATA_W;
   localparam int CSR_IDX_W = 4;
   localparam int DIV_STEPS = QUO_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // generator multiplier, modulus 2^31-1
   localparam logic [MULT_W-1:0]  GEN_MULT   = 30'd742938285;
   localparam logic [STATE_W-1:0] SEED_RESET = 31'd1;
   // draw offset 2^30 turns the state into a q1.31 value in [-0.5,0.5)
   localparam logic [DATA_W-1:0]  XQ_OFFSET  = 32'h4000_0000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SLIDING_MODE = 4'd0,
      CSR_AMP_RATE     = 4'd1,
      CSR_FREQ_RATE    = 4'd2,
      CSR_SEED_INIT    = 4'd3
   } spbj_csr_index_type;

   typedef struct packed {
      logic capture;
      logic draw_mul;
      logic draw_red;
      logic jit_mul;
      logic jit_load;
      logic div_step;
      logic finish_amp;
      logic finish_out;
      logic amp_phase;
   } spbj_cmd_type;

   typedef struct packed {
      logic sliding_mode;
      logic out_free;
   } spbj_status_type;

endpackage

>>> hdl/spbj_if.sv
// spbj channel interfaces: input bin, result bin and register write channel
// depends on spbj_pkg for field widths
`timescale 1ns / 1ps

interface spbj_req_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [spbj_pkg::DATA_W-1:0]   amp_in;
   logic signed [spbj_pkg::DATA_W-1:0]   freq_in;
   logic        [spbj_pkg::BIN_W-1:0]    bin_index;

   modport source (output valid, output amp_in, output freq_in, output bin_index,
                   input ready);
   modport sink   (input valid, input amp_in, input freq_in, input bin_index,
                   output ready);
endinterface

interface spbj_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [spbj_pkg::DATA_W-1:0]   amp_out;
   logic signed [spbj_pkg::DATA_W-1:0]   freq_out;

   modport source (output valid, output amp_out, output freq_out, input ready);
   modport sink   (input valid, input amp_out, input freq_out, output ready);
endinterface

interface spbj_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [spbj_pkg::CSR_IDX_W-1:0]       index;
   logic [spbj_pkg::DATA_W-1:0]          data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> hdl/spectral_bin_random_jitter_top.sv
// spectral_bin_random_jitter_top: top level joining sequencer and datapath
// depends on spbj_pkg, spbj_if, spbj_ctrl and spbj_datapath
`timescale 1ns / 1ps

// Adds random jitter to one spectral bin (amplitude, frequency, bin index k)
// per item, all values signed q16.16. A 31-bit multiplicative generator
// (modulus 2^31-1) advances once per draw and gives x in [-0.5,0.5). In frame
// mode the amplitude passes and the frequency gets freq_rate*x/(2k+1); in
// sliding mode the amplitude gets amp_rate*x and the frequency, from a second
// draw, freq_rate*x/(k+1). Quotients truncate toward zero and sums saturate.
// One item is worked at a time, through a draw/multiply pass per draw (two in
// sliding mode) and the 31-step radix-2 divider for the frequency term. The
// result sits in an output register, so the next item is accepted while it
// waits. Writing seed_init reloads the generator.
// Registers: 0 sliding_mode, 1 amp_rate, 2 freq_rate, 3 seed_init; writes to
// other indexes are ignored, writes are always taken and are meant for idle.

module spectral_bin_random_jitter_top (
   input  logic        clock,
   input  logic        reset,
   spbj_req_if.sink    req_chan,
   spbj_rsp_if.source  rsp_chan,
   spbj_csr_if.sink    csr_chan
);

   spbj_pkg::spbj_cmd_type    cmd;
   spbj_pkg::spbj_status_type status;

   // register writes never stall
   assign csr_chan.ready = 1'b1;

   // sequencer: one-hot state machine, owns the input handshake
   spbj_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: config registers, generator, multiply, divider, result register
   spbj_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_chan.valid),
      .csr_index (csr_chan.index),
      .csr_data  (csr_chan.data),
      .amp_in    (req_chan.amp_in),
      .freq_in   (req_chan.freq_in),
      .bin_index (req_chan.bin_index),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .amp_out   (rsp_chan.amp_out),
      .freq_out  (rsp_chan.freq_out)
   );

endmodule

>>> hdl/spbj_ctrl.sv
// spbj_ctrl: sequencer for draw, multiply, divide and finish steps
// depends on spbj_pkg (command and status types, step counts)
`timescale 1ns / 1ps

module spbj_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  spbj_pkg::spbj_status_type status,
   output spbj_pkg::spbj_cmd_type    cmd
);

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_DRAW_MUL = 7'b0000010,
      ST_DRAW_RED = 7'b0000100,
      ST_JIT_MUL  = 7'b0001000,
      ST_JIT_LOAD = 7'b0010000,
      ST_DIVIDE   = 7'b0100000,
      ST_FINISH   = 7'b1000000
   } spbj_state_type;

   localparam logic [spbj_pkg::CNT_W-1:0] CNT_LAST = spbj_pkg::CNT_W'(spbj_pkg::DIV_STEPS - 1);

   spbj_state_type                state_ff, state_in;
   logic                          phase_ff, phase_in;
   logic [spbj_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.amp_phase = phase_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               phase_in    = status.sliding_mode;
               state_in    = ST_DRAW_MUL;
            end
         end
         ST_DRAW_MUL: begin
            cmd.draw_mul = 1'b1;
            state_in     = ST_DRAW_RED;
         end
         ST_DRAW_RED: begin
            cmd.draw_red = 1'b1;
            state_in     = ST_JIT_MUL;
         end
         ST_JIT_MUL: begin
            cmd.jit_mul = 1'b1;
            state_in    = ST_JIT_LOAD;
         end
         ST_JIT_LOAD: begin
            cmd.jit_load = 1'b1;
            cnt_in       = '0;
            // amplitude term divides by one: no iterations needed
            state_in     = phase_ff ? ST_FINISH : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (phase_ff) begin
               cmd.finish_amp = 1'b1;
               phase_in       = 1'b0;
               state_in       = ST_DRAW_MUL;
            end else if (status.out_free) begin
               cmd.finish_out = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> cnt_ff <= CNT_LAST)
      else $error("divide step count out of range");

   a_accept_phase: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_DRAW_MUL
                                 && phase_ff == $past(status.sliding_mode))
      else $error("accepted item did not start with the right phase");

   a_amp_to_freq: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && phase_ff |=> state_ff == ST_DRAW_MUL && !phase_ff)
      else $error("amplitude phase not followed by frequency draw");
`endif

endmodule

>>> hdl/spbj_datapath.sv
// spbj_datapath: registers, generator, gain multiply, restoring divider, saturation
// depends on spbj_pkg (widths, constants, command and status types)
`timescale 1ns / 1ps

module spbj_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  spbj_pkg::spbj_cmd_type           cmd,
   output spbj_pkg::spbj_status_type        status,
   input  logic                             csr_valid,
   input  logic [spbj_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spbj_pkg::DATA_W-1:0]      csr_data,
   input  logic [spbj_pkg::DATA_W-1:0]      amp_in,
   input  logic [spbj_pkg::DATA_W-1:0]      freq_in,
   input  logic [spbj_pkg::BIN_W-1:0]       bin_index,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [spbj_pkg::DATA_W-1:0]      amp_out,
   output logic [spbj_pkg::DATA_W-1:0]      freq_out
);

   localparam int DW = spbj_pkg::DATA_W;
   localparam int SW = spbj_pkg::STATE_W;
   localparam int QW = spbj_pkg::QUO_W;
   localparam int RW = spbj_pkg::DIVR_W;

   // configuration
   logic                         mode_ff, mode_in;
   logic [DW-1:0]                amp_rate_ff, amp_rate_in;
   logic [DW-1:0]                freq_rate_ff, freq_rate_in;
   logic [SW-1:0]                gen_state_ff, gen_state_in;
   // item payload and working registers
   logic [DW-1:0]                amp_ff, amp_in_nx;
   logic [DW-1:0]                freq_ff, freq_in_nx;
   logic [spbj_pkg::BIN_W-1:0]   k_ff, k_in;
   logic [DW-1:0]                amp_res_ff, amp_res_in;
   logic [spbj_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [spbj_pkg::NUM_W-1:0]   num_ff, num_in;
   logic                         neg_ff, neg_in;
   logic [QW-1:0]                quo_ff, quo_in;
   logic [RW-1:0]                rem_ff, rem_in;
   logic [RW-1:0]                div_ff, div_in;
   // result register
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0]                rsp_amp_ff, rsp_amp_in;
   logic [DW-1:0]                rsp_freq_ff, rsp_freq_in;

   logic [DW-1:0]                fold;
   logic [DW-1:0]                xq;
   logic [DW-1:0]                rate_sel;
   logic [spbj_pkg::NUM_W-1:0]   abs_num;
   logic [RW:0]                  trial;
   logic                         fits;
   logic [DW:0]                  quo_ext;
   logic [DW:0]                  term;
   logic [DW-1:0]                base;
   logic [DW+1:0]                sum;
   logic [DW-1:0]                sat;
   logic                         out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign status.sliding_mode = mode_ff;
   assign status.out_free     = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign amp_out   = rsp_amp_ff;
   assign freq_out  = rsp_freq_ff;

   always_comb begin
      // mersenne fold of the product, the second fold cannot carry out
      fold     = {1'b0, prod_ff[SW-1:0]} + {2'b00, prod_ff[spbj_pkg::PROD_W-1:SW]};
      xq       = {1'b0, gen_state_ff} - spbj_pkg::XQ_OFFSET;
      rate_sel = cmd.amp_phase ? amp_rate_ff : freq_rate_ff;
      abs_num  = num_ff[spbj_pkg::NUM_W-1] ? (~num_ff + 1'b1) : num_ff;
      trial    = {rem_ff, quo_ff[QW-1]};
      fits     = trial >= {1'b0, div_ff};
      quo_ext  = {{(DW + 1 - QW){1'b0}}, quo_ff};
      term     = neg_ff ? (~quo_ext + 1'b1) : quo_ext;
      base     = cmd.amp_phase ? amp_ff : freq_ff;
      sum      = {{2{base[DW-1]}}, base} + {term[DW], term};
      if (sum[DW+1:DW-1] == 3'b000 || sum[DW+1:DW-1] == 3'b111) begin
         sat = sum[DW-1:0];
      end else if (sum[DW+1]) begin
         sat = {1'b1, {(DW-1){1'b0}}};
      end else begin
         sat = {1'b0, {(DW-1){1'b1}}};
      end
   end

   always_comb begin
      mode_in      = mode_ff;
      amp_rate_in  = amp_rate_ff;
      freq_rate_in = freq_rate_ff;
      gen_state_in = gen_state_ff;
      amp_in_nx    = amp_ff;
      freq_in_nx   = freq_ff;
      k_in         = k_ff;
      amp_res_in   = amp_res_ff;
      prod_in      = prod_ff;
      num_in       = num_ff;
      neg_in       = neg_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_amp_in   = rsp_amp_ff;
      rsp_freq_in  = rsp_freq_ff;

      if (csr_valid) begin
         unique case (csr_index)
            spbj_pkg::CSR_SLIDING_MODE: mode_in      = csr_data[0];
            spbj_pkg::CSR_AMP_RATE:     amp_rate_in  = csr_data;
            spbj_pkg::CSR_FREQ_RATE:    freq_rate_in = csr_data;
            spbj_pkg::CSR_SEED_INIT:    gen_state_in = csr_data[SW-1:0];
            default: begin
            end
         endcase
      end

      if (cmd.capture) begin
         amp_in_nx  = amp_in;
         freq_in_nx = freq_in;
         k_in       = bin_index;
         amp_res_in = amp_in;
      end
      if (cmd.draw_mul) begin
         prod_in = spbj_pkg::PROD_W'(gen_state_ff) * spbj_pkg::PROD_W'(spbj_pkg::GEN_MULT);
      end
      if (cmd.draw_red) begin
         gen_state_in = fold[SW-1:0] + {{(SW-1){1'b0}}, fold[DW-1]};
      end
      if (cmd.jit_mul) begin
         num_in = spbj_pkg::NUM_W'($signed(rate_sel)) * spbj_pkg::NUM_W'($signed(xq));
      end
      if (cmd.jit_load) begin
         // drop the 2^31 scale first, then divide by the bin divisor
         neg_in = num_ff[spbj_pkg::NUM_W-1];
         quo_in = abs_num[QW + DW - 2:DW - 1];
         rem_in = '0;
         div_in = mode_ff ? ({1'b0, k_ff} + 1'b1) : {k_ff, 1'b1};
      end
      if (cmd.div_step) begin
         rem_in = fits ? (trial[RW-1:0] - div_ff) : trial[RW-1:0];
         quo_in = {quo_ff[QW-2:0], fits};
      end
      if (cmd.finish_amp) begin
         amp_res_in = sat;
      end

      if (cmd.finish_out) begin
         rsp_valid_in = 1'b1;
         rsp_amp_in   = amp_res_ff;
         rsp_freq_in  = sat;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         amp_rate_ff  <= '0;
         freq_rate_ff <= '0;
         gen_state_ff <= spbj_pkg::SEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         amp_rate_ff  <= amp_rate_in;
         freq_rate_ff <= freq_rate_in;
         gen_state_ff <= gen_state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      amp_ff      <= amp_in_nx;
      freq_ff     <= freq_in_nx;
      k_ff        <= k_in;
      amp_res_ff  <= amp_res_in;
      prod_ff     <= prod_in;
      num_ff      <= num_in;
      neg_ff      <= neg_in;
      quo_ff      <= quo_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      rsp_amp_ff  <= rsp_amp_in;
      rsp_freq_ff <= rsp_freq_in;
   end

`ifndef SYNTHESIS
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish_out |-> out_free)
      else $error("result written while previous item still held");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> rem_ff < div_ff && div_ff != '0)
      else $error("divider remainder out of range");

   a_out_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish_out |=> rsp_valid_ff)
      else $error("finished item not presented");
`endif

endmodule

>>> dv/tb_top.sv
// tb_top: self-checking bench for spectral_bin_random_jitter_top
// depends on spbj_pkg, the spbj channel interfaces and the rtl of the block
`timescale 1ns / 1ps

module tb_top;

   import spbj_pkg::*;

   // run limits and timing
   localparam int  RESET_CYCLES  = 12;
   localparam int  SETTLE_CYCLES = 60;
   localparam int  HOLD_CYCLES   = 400;     // long receiver stall
   localparam int  CYCLE_LIMIT   = 500000;
   localparam int  SEGMENTS      = 6;
   localparam int  SEGMENT_BINS  = 88;
   localparam int  CSR_SLOTS     = 1 << CSR_IDX_W;
   localparam int  BIN_MAX       = (1 << BIN_W) - 1;

   localparam logic [DATA_W-1:0]  Q_MAX     = 32'h7fff_ffff;
   localparam logic [DATA_W-1:0]  Q_MIN     = 32'h8000_0000;
   localparam logic [STATE_W-1:0] SEED_HIGH = 31'h7fff_fffe;  // largest normal seed
   localparam logic [STATE_W-1:0] SEED_STUCK_HIGH = 31'h7fff_ffff;
   localparam longint SAT_HI   = 64'sd2147483647;
   localparam longint SAT_LO   = -64'sd2147483648;
   localparam longint DRAW_MID = 64'sd1073741824;   // 2^30

   typedef struct packed {
      logic [DATA_W-1:0] amp;
      logic [DATA_W-1:0] freq;
   } jittered_bin_t;

   logic clock;
   logic reset;

   spbj_req_if req_bus ();
   spbj_rsp_if rsp_bus ();
   spbj_csr_if csr_bus ();

   spectral_bin_random_jitter_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // predictor copy of the registers and the generator
   logic               mode_sliding;
   logic [DATA_W-1:0]  amp_gain;
   logic [DATA_W-1:0]  freq_gain;
   logic [STATE_W-1:0] gen_value;

   jittered_bin_t pending_bins[$];

   // handshake shaping
   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int hold_seen;
   int hold_left;

   // bookkeeping
   int errors;
   int bins_sent;
   int bins_checked;
   int csr_writes;
   int cycle_count;

   // clock, 10 ns period
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d bins still pending",
                  cycle_count, pending_bins.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------

   // one generator step: multiply, then fold the bits above bit 30 twice
   function automatic logic [STATE_W-1:0] advance_generator(input logic [STATE_W-1:0] s);
      logic [PROD_W-1:0] prod;
      logic [31:0]       fold;
      prod = PROD_W'(s) * PROD_W'(GEN_MULT);
      fold = {1'b0, prod[30:0]} + {2'b00, prod[PROD_W-1:31]};
      return fold[30:0] + STATE_W'(fold[31]);
   endfunction

   // draw from the generator as a q1.31 value (state - 2^30)
   function automatic longint draw_offset();
      gen_value = advance_generator(gen_value);
      return longint'(gen_value) - DRAW_MID;
   endfunction

   // base + rate*x/(divisor*2^31), truncated toward zero, then saturated
   function automatic logic [DATA_W-1:0] add_jitter(input logic signed [DATA_W-1:0] base,
                                                    input logic signed [DATA_W-1:0] rate,
                                                    input longint xq,
                                                    input longint divisor);
      longint num;
      longint den;
      longint sum;
      num = longint'(rate) * xq;
      den = divisor * (longint'(1) << 31);
      sum = longint'(base) + num / den;
      if (sum > SAT_HI) sum = SAT_HI;
      if (sum < SAT_LO) sum = SAT_LO;
      return sum[DATA_W-1:0];
   endfunction

   function automatic jittered_bin_t predict_jittered_bin(input logic signed [DATA_W-1:0] amp,
                                                          input logic signed [DATA_W-1:0] freq,
                                                          input logic [BIN_W-1:0] k);
      jittered_bin_t r;
      longint        xq;
      if (mode_sliding) begin
         // amplitude from the first draw, frequency from the second
         xq     = draw_offset();
         r.amp  = add_jitter(amp, amp_gain, xq, 1);
         xq     = draw_offset();
         r.freq = add_jitter(freq, freq_gain, xq, longint'(k) + 1);
      end else begin
         // frame mode: amplitude passes, odd divisor 2k+1
         xq     = draw_offset();
         r.amp  = amp;
         r.freq = add_jitter(freq, freq_gain, xq, 2 * longint'(k) + 1);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // result side: ready shaping and checking
   // ---------------------------------------------------------------------

   // receiver ready; a new hold request starts a long stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_seen != hold_requests) begin
         hold_seen     <= hold_requests;
         hold_left     <= HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left     <= hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // compare every accepted result with the oldest prediction
   always @(posedge clock) begin
      jittered_bin_t want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_bins.size() == 0) begin
            $error("result with no bin pending: amp_out %0d freq_out %0d",
                   rsp_bus.amp_out, rsp_bus.freq_out);
            errors++;
         end else begin
            want = pending_bins.pop_front();
            bins_checked++;
            if (rsp_bus.amp_out !== want.amp) begin
               $error("amp_out mismatch: expected %0d, actual %0d",
                      $signed(want.amp), rsp_bus.amp_out);
               errors++;
            end
            if (rsp_bus.freq_out !== want.freq) begin
               $error("freq_out mismatch: expected %0d, actual %0d",
                      $signed(want.freq), rsp_bus.freq_out);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------

   // offer one bin, with a random gap first, and predict it once accepted
   task automatic send_bin(input logic [DATA_W-1:0] amp, input logic [DATA_W-1:0] freq,
                           input logic [BIN_W-1:0] k);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.amp_in    <= amp;
      req_bus.freq_in   <= freq;
      req_bus.bin_index <= k;
      do @(posedge clock); while (!req_bus.ready);
      pending_bins.push_back(predict_jittered_bin(amp, freq, k));
      bins_sent++;
   endtask

   // register write; the predictor follows the same masking as the block
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      case (idx)
         CSR_SLIDING_MODE: mode_sliding = value[0];
         CSR_AMP_RATE:     amp_gain     = value;
         CSR_FREQ_RATE:    freq_gain    = value;
         CSR_SEED_INIT:    gen_value    = value[STATE_W-1:0];
         default: ;   // unmapped index, nothing changes
      endcase
      csr_writes++;
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // stop offering, let every pending bin come back, then settle
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_bins.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // random gains lean toward the extremes so saturation shows up
   function automatic logic [DATA_W-1:0] random_gain();
      case ($urandom_range(5))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2:       return '0;
         3:       return $urandom_range(1, 1 << 18) * ($urandom_range(1) ? 1 : -1);
         default: return $urandom;
      endcase
   endfunction

   // bin values: near the rails, in a plausible audio range, or anything
   function automatic logic [DATA_W-1:0] random_value();
      case ($urandom_range(7))
         0:       return Q_MAX - $urandom_range(255);
         1:       return Q_MIN + $urandom_range(255);
         2:       return $urandom_range(22050 << 16);
         default: return $urandom;
      endcase
   endfunction

   // mostly the nominal half frame, sometimes the full index range
   function automatic logic [BIN_W-1:0] random_bin_index();
      if ($urandom_range(3) == 0)
         return BIN_W'($urandom_range(BIN_MAX));
      return BIN_W'($urandom_range(1024));
   endfunction

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // reset values: frame mode, zero gains, so frequency comes back unchanged
   task automatic test_reset_state();
      send_bin(Q_MAX, Q_MIN, '0);
      send_bin(Q_MIN, Q_MAX, BIN_W'(BIN_MAX));
      send_bin('0, '0, 11'd1024);
      send_bin($urandom, $urandom, 11'd1);
   endtask

   // frame mode with full-scale gains, divisor 1 pushes the sum into the rails
   task automatic test_frame_saturation();
      wait_idle();
      write_csr(CSR_SLIDING_MODE, '0);
      write_csr(CSR_FREQ_RATE, Q_MAX);
      write_csr(CSR_SEED_INIT, 32'(SEED_RESET));
      send_bin(Q_MAX, Q_MAX - 32'd5, '0);
      send_bin(Q_MIN, Q_MIN + 32'd5, '0);
      send_bin(32'h0001_0000, Q_MAX, '0);
      wait_idle();
      write_csr(CSR_FREQ_RATE, Q_MIN);
      send_bin($urandom, Q_MIN, '0);
      send_bin($urandom, Q_MAX, 11'd1024);
      send_bin($urandom, $urandom, BIN_W'(BIN_MAX));
   endtask

   // sliding mode, two draws per bin, amplitude jitter at both gain extremes
   task automatic test_sliding_saturation();
      wait_idle();
      write_csr(CSR_SLIDING_MODE, 32'd1);
      write_csr(CSR_AMP_RATE, Q_MIN);
      write_csr(CSR_FREQ_RATE, Q_MAX);
      write_csr(CSR_SEED_INIT, 32'(SEED_HIGH));
      send_bin(Q_MAX, Q_MAX, '0);
      send_bin(Q_MIN, Q_MIN, BIN_W'(BIN_MAX));
      wait_idle();
      write_csr(CSR_AMP_RATE, Q_MAX);
      send_bin(Q_MAX, Q_MIN, '0);
      send_bin(Q_MIN, Q_MAX, 11'd1024);
      send_bin($urandom, $urandom, 11'd7);
   endtask

   // seeds of zero and all ones lock the generator onto one value
   task automatic test_degenerate_seeds();
      wait_idle();
      write_csr(CSR_SEED_INIT, '0);
      send_bin(Q_MAX, Q_MAX, '0);
      send_bin(Q_MIN, Q_MIN, 11'd3);
      wait_idle();
      write_csr(CSR_SLIDING_MODE, '0);
      write_csr(CSR_SEED_INIT, 32'(SEED_STUCK_HIGH));
      send_bin(Q_MAX, Q_MAX, '0);
      send_bin($urandom, Q_MIN, 11'd2);
   endtask

   // upper data bits are dropped, unmapped indexes change nothing
   task automatic test_register_masking();
      wait_idle();
      write_csr(CSR_SLIDING_MODE, 32'hffff_fffe);
      write_csr(CSR_SEED_INIT, 32'h8000_1234);
      write_csr(CSR_FREQ_RATE, 32'h0040_0000);
      for (int i = int'(CSR_SEED_INIT) + 1; i < CSR_SLOTS; i++)
         write_csr(CSR_IDX_W'(i), $urandom);
      send_bin($urandom, $urandom, '0);
      send_bin($urandom, $urandom, 11'd512);
      send_bin($urandom, $urandom, BIN_W'(BIN_MAX));
   endtask

   // receiver stalls for a long stretch while bins keep coming
   task automatic test_backpressure();
      wait_idle();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      for (int i = 0; i < 10; i++)
         send_bin(random_value(), random_value(), random_bin_index());
   endtask

   // random segments, each with its own register setting
   task automatic run_segments();
      for (int s = 0; s < SEGMENTS; s++) begin
         wait_idle();
         write_csr(CSR_SLIDING_MODE, 32'($urandom_range(1)));
         write_csr(CSR_AMP_RATE, random_gain());
         write_csr(CSR_FREQ_RATE, random_gain());
         // sometimes keep the generator running across segments
         if ($urandom_range(1))
            write_csr(CSR_SEED_INIT, $urandom_range(32'(SEED_HIGH), 1));
         for (int i = 0; i < SEGMENT_BINS; i++)
            send_bin(random_value(), random_value(), random_bin_index());
      end
   endtask

   // three idling patterns: slow receiver, slow sender, full rate
   task automatic test_random_traffic();
      send_idle_pct = 26;
      recv_idle_pct = 86;
      run_segments();
      send_idle_pct = 86;
      recv_idle_pct = 26;
      run_segments();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_segments();
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      // known values on every input from time zero
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.amp_in    = '0;
      req_bus.freq_in   = '0;
      req_bus.bin_index = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = '0;
      csr_bus.data      = '0;

      // predictor starts from the reset values of the block
      mode_sliding  = 1'b0;
      amp_gain      = '0;
      freq_gain     = '0;
      gen_value     = SEED_RESET;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests = 0;
      hold_seen     = 0;
      hold_left     = 0;
      errors        = 0;
      bins_sent     = 0;
      bins_checked  = 0;
      csr_writes    = 0;
      cycle_count   = 0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_frame_saturation();
      test_sliding_saturation();
      test_degenerate_seeds();
      test_register_masking();
      test_backpressure();
      test_random_traffic();
      wait_idle();

      $display("covered %0d bins (%0d checked) and %0d register writes in %0d cycles",
               bins_sent, bins_checked, csr_writes, cycle_count);
      $display("frame and sliding modes, rail saturation, stuck seeds, masking, long stall");
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches", errors);
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
